// ----- rtl/pdf_pkg.sv -----
package pdf_pkg;

	localparam int REG_COUNT  = 15;
	localparam int SLOT_COUNT = 5;
	localparam int REG_IDX_W  = $clog2(REG_COUNT);
	localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);

	typedef logic [3:0]  reg_id_t;
	typedef logic [3:0]  icode_t;
	typedef logic [63:0] word_t;

	localparam reg_id_t RNONE = 4'd15;
	localparam reg_id_t RSP   = 4'd4;

	localparam icode_t IRRMOVQ = 4'd2;
	localparam icode_t IIRMOVQ = 4'd3;
	localparam icode_t IRMMOVQ = 4'd4;
	localparam icode_t IMRMOVQ = 4'd5;
	localparam icode_t IOPQ    = 4'd6;
	localparam icode_t IJXX    = 4'd7;
	localparam icode_t ICALL   = 4'd8;
	localparam icode_t IRET    = 4'd9;
	localparam icode_t IPUSHQ  = 4'd10;
	localparam icode_t IPOPQ   = 4'd11;

	typedef enum logic [1:0] {
		ACT_DECODE = 2'd0,
		ACT_WRITE  = 2'd1,
		ACT_SLOT   = 2'd2
	} action_t;

	typedef struct packed {
		reg_id_t src_a;
		reg_id_t src_b;
		reg_id_t dst_e;
		reg_id_t dst_m;
		logic    use_valp;
	} dec_t;

	typedef struct packed {
		logic  hit_a;
		logic  hit_b;
		word_t val_a;
		word_t val_b;
	} fwd_t;

endpackage

// ----- rtl/pdf_ram.sv -----
module pdf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 15
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ----- rtl/pdf_decode.sv -----
module pdf_decode (
	input  pdf_pkg::icode_t  icode,
	input  pdf_pkg::reg_id_t reg_a,
	input  pdf_pkg::reg_id_t reg_b,
	output pdf_pkg::dec_t    dec
);
	import pdf_pkg::*;

	always_comb begin
		dec = '{src_a: RNONE, src_b: RNONE, dst_e: RNONE, dst_m: RNONE, use_valp: 1'b0};
		unique case (icode)
			IRRMOVQ: begin
				dec.src_a = reg_a;
				dec.dst_e = reg_b;
			end
			IIRMOVQ: begin
				dec.dst_e = reg_b;
			end
			IRMMOVQ: begin
				dec.src_a = reg_a;
				dec.src_b = reg_b;
			end
			IMRMOVQ: begin
				dec.src_b = reg_b;
				dec.dst_m = reg_a;
			end
			IOPQ: begin
				dec.src_a = reg_a;
				dec.src_b = reg_b;
				dec.dst_e = reg_b;
			end
			IJXX: begin
				dec.use_valp = 1'b1;
			end
			ICALL: begin
				dec.src_b    = RSP;
				dec.dst_e    = RSP;
				dec.use_valp = 1'b1;
			end
			IRET: begin
				dec.src_a = RSP;
				dec.src_b = RSP;
				dec.dst_e = RSP;
			end
			IPUSHQ: begin
				dec.src_a = reg_a;
				dec.src_b = RSP;
				dec.dst_e = RSP;
			end
			IPOPQ: begin
				dec.src_a = RSP;
				dec.src_b = RSP;
				dec.dst_e = RSP;
				dec.dst_m = reg_a;
			end
			default: begin
				dec.use_valp = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/pdf_bypass.sv -----
module pdf_bypass (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [2:0]       slot,
	input  pdf_pkg::reg_id_t dest_reg,
	input  pdf_pkg::word_t   write_value,
	input  pdf_pkg::reg_id_t src_a,
	input  pdf_pkg::reg_id_t src_b,
	output pdf_pkg::fwd_t    fwd
);
	import pdf_pkg::*;

	reg_id_t dest_q  [SLOT_COUNT];
	word_t   value_q [SLOT_COUNT];
	logic    load_ok;

	assign load_ok = load && (slot < 3'(SLOT_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				dest_q[i] <= RNONE;
			end
		end else if (load_ok) begin
			dest_q[slot[SLOT_IDX_W-1:0]] <= dest_reg;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			value_q[slot[SLOT_IDX_W-1:0]] <= write_value;
		end
	end

	// lowest slot number has priority
	always_comb begin
		fwd = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (dest_q[i] != RNONE && dest_q[i] == src_a) begin
				fwd.hit_a = 1'b1;
				fwd.val_a = value_q[i];
			end
			if (dest_q[i] != RNONE && dest_q[i] == src_b) begin
				fwd.hit_b = 1'b1;
				fwd.val_b = value_q[i];
			end
		end
	end

endmodule

// ----- rtl/pipeline_decode_forwarding.sv -----
// Y86-64 decode stage: register file, five forwarding slots and operand selection.
// Each item is a decode, a register write or a forwarding-slot load; only a decode
// yields a result item. One item is taken per clock unless in_stall is high; a decode
// result passes the registered register-file read and stage-1 registers, then the
// result register. Writes and slot loads take effect at acceptance, so later
// decodes see them and earlier ones do not. Register 15 means none and reads as zero.
module pipeline_decode_forwarding (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       action,
	input  pdf_pkg::icode_t  icode,
	input  logic [3:0]       ifun,
	input  pdf_pkg::reg_id_t reg_a,
	input  pdf_pkg::reg_id_t reg_b,
	input  pdf_pkg::word_t   const_word,
	input  pdf_pkg::word_t   next_pc,
	input  logic [2:0]       slot,
	input  pdf_pkg::reg_id_t dest_reg,
	input  pdf_pkg::word_t   write_value,
	output logic             out_valid,
	input  logic             out_stall,
	output pdf_pkg::icode_t  e_icode,
	output logic [3:0]       e_ifun,
	output pdf_pkg::reg_id_t dst_e,
	output pdf_pkg::reg_id_t dst_m,
	output pdf_pkg::word_t   e_valc,
	output pdf_pkg::word_t   val_a,
	output pdf_pkg::word_t   val_b,
	output pdf_pkg::reg_id_t src_a,
	output pdf_pkg::reg_id_t src_b
);
	import pdf_pkg::*;

	logic     accept, advance;
	logic     is_decode, is_write, is_slot, rf_we;
	dec_t     dec;
	fwd_t     fwd;
	logic     ok_a, ok_b;
	word_t    rf_a, rf_b;
	logic [REG_COUNT-1:0] rf_valid_q;

	logic     vld_s1;
	icode_t   icode_s1;
	logic [3:0] ifun_s1;
	word_t    valc_s1, valp_s1;
	dec_t     dec_s1;
	fwd_t     fwd_s1;
	logic     ok_a_s1, ok_b_s1;

	logic     out_valid_q;
	icode_t   icode_q;
	logic [3:0] ifun_q;
	reg_id_t  dst_e_q, dst_m_q, src_a_q, src_b_q;
	word_t    valc_q, val_a_q, val_b_q;
	word_t    val_a_nx, val_b_nx;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = vld_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		is_decode = 1'b0;
		is_write  = 1'b0;
		is_slot   = 1'b0;
		unique case (action)
			ACT_DECODE: is_decode = 1'b1;
			ACT_WRITE:  is_write  = 1'b1;
			ACT_SLOT:   is_slot   = 1'b1;
			default:    is_decode = 1'b0;
		endcase
	end

	assign rf_we = accept && is_write && (dest_reg < 4'(REG_COUNT));

	pdf_decode u_decode (
		.icode (icode),
		.reg_a (reg_a),
		.reg_b (reg_b),
		.dec   (dec)
	);

	pdf_bypass u_bypass (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept && is_slot),
		.slot        (slot),
		.dest_reg    (dest_reg),
		.write_value (write_value),
		.src_a       (dec.src_a),
		.src_b       (dec.src_b),
		.fwd         (fwd)
	);

	pdf_ram #(
		.WIDTH (64),
		.DEPTH (REG_COUNT)
	) u_regfile (
		.clk     (clk),
		.we      (rf_we),
		.waddr   (dest_reg[REG_IDX_W-1:0]),
		.wdata   (write_value),
		.re      (accept && is_decode),
		.raddr_a (dec.src_a[REG_IDX_W-1:0]),
		.raddr_b (dec.src_b[REG_IDX_W-1:0]),
		.rdata_a (rf_a),
		.rdata_b (rf_b)
	);

	// unwritten entries read as zero
	assign ok_a = (dec.src_a < 4'(REG_COUNT)) && rf_valid_q[dec.src_a[REG_IDX_W-1:0]];
	assign ok_b = (dec.src_b < 4'(REG_COUNT)) && rf_valid_q[dec.src_b[REG_IDX_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_valid_q  <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rf_we) begin
				rf_valid_q[dest_reg[REG_IDX_W-1:0]] <= 1'b1;
			end
			if (accept) begin
				vld_s1 <= is_decode;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_decode) begin
			icode_s1 <= icode;
			ifun_s1  <= ifun;
			valc_s1  <= const_word;
			valp_s1  <= next_pc;
			dec_s1   <= dec;
			fwd_s1   <= fwd;
			ok_a_s1  <= ok_a;
			ok_b_s1  <= ok_b;
		end
	end

	always_comb begin
		if (dec_s1.use_valp) begin
			val_a_nx = valp_s1;
		end else if (fwd_s1.hit_a) begin
			val_a_nx = fwd_s1.val_a;
		end else if (ok_a_s1) begin
			val_a_nx = rf_a;
		end else begin
			val_a_nx = '0;
		end
		if (fwd_s1.hit_b) begin
			val_b_nx = fwd_s1.val_b;
		end else if (ok_b_s1) begin
			val_b_nx = rf_b;
		end else begin
			val_b_nx = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			icode_q <= icode_s1;
			ifun_q  <= ifun_s1;
			dst_e_q <= dec_s1.dst_e;
			dst_m_q <= dec_s1.dst_m;
			src_a_q <= dec_s1.src_a;
			src_b_q <= dec_s1.src_b;
			valc_q  <= valc_s1;
			val_a_q <= val_a_nx;
			val_b_q <= val_b_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign e_icode   = icode_q;
	assign e_ifun    = ifun_q;
	assign dst_e     = dst_e_q;
	assign dst_m     = dst_m_q;
	assign e_valc    = valc_q;
	assign val_a     = val_a_q;
	assign val_b     = val_b_q;
	assign src_a     = src_a_q;
	assign src_b     = src_b_q;

endmodule

// ----- tb/pipeline_decode_forwarding_test.sv -----
`timescale 1ns / 1ps

module pipeline_decode_forwarding_test;

	import pdf_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 950;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [1:0] act;
		icode_t     icode;
		logic [3:0] ifun;
		reg_id_t    ra;
		reg_id_t    rb;
		word_t      valc;
		word_t      valp;
		logic [2:0] slot;
		reg_id_t    dest;
		word_t      wval;
	} request_t;

	typedef struct packed {
		icode_t     icode;
		logic [3:0] ifun;
		reg_id_t    dst_e;
		reg_id_t    dst_m;
		word_t      valc;
		word_t      val_a;
		word_t      val_b;
		reg_id_t    src_a;
		reg_id_t    src_b;
	} operands_t;

	// Tracks register file and bypass slots; queues the operands each decode should yield.
	class operand_tracker;
		word_t     reg_file[REG_COUNT];
		reg_id_t   fwd_dest[SLOT_COUNT];
		word_t     fwd_value[SLOT_COUNT];
		operands_t expected[$];
		int        errors;

		function new();
			foreach (reg_file[i]) reg_file[i] = '0;
			foreach (fwd_dest[i]) begin
				fwd_dest[i] = RNONE;
				fwd_value[i] = '0;
			end
			errors = 0;
		endfunction

		function word_t operand_of(reg_id_t src);
			if (src == RNONE)
				return '0;
			for (int s = 0; s < SLOT_COUNT; s++)
				if (fwd_dest[s] == src)
					return fwd_value[s];
			if (src < REG_COUNT)
				return reg_file[src];
			return '0;
		endfunction

		function void note_item(request_t rq);
			operands_t r;
			if (rq.act == ACT_WRITE) begin
				if (rq.dest != RNONE && rq.dest < REG_COUNT)
					reg_file[rq.dest] = rq.wval;
				return;
			end
			if (rq.act == ACT_SLOT) begin
				if (rq.slot < SLOT_COUNT) begin
					fwd_dest[rq.slot] = rq.dest;
					fwd_value[rq.slot] = rq.wval;
				end
				return;
			end
			if (rq.act != ACT_DECODE)
				return;
			r.icode = rq.icode;
			r.ifun = rq.ifun;
			r.valc = rq.valc;
			r.src_a = RNONE;
			r.src_b = RNONE;
			r.dst_e = RNONE;
			r.dst_m = RNONE;
			case (rq.icode)
				IRRMOVQ: begin
					r.src_a = rq.ra;
					r.dst_e = rq.rb;
				end
				IIRMOVQ: r.dst_e = rq.rb;
				IRMMOVQ: begin
					r.src_a = rq.ra;
					r.src_b = rq.rb;
				end
				IMRMOVQ: begin
					r.src_b = rq.rb;
					r.dst_m = rq.ra;
				end
				IOPQ: begin
					r.src_a = rq.ra;
					r.src_b = rq.rb;
					r.dst_e = rq.rb;
				end
				ICALL: begin
					r.src_b = RSP;
					r.dst_e = RSP;
				end
				IRET: begin
					r.src_a = RSP;
					r.src_b = RSP;
					r.dst_e = RSP;
				end
				IPUSHQ: begin
					r.src_a = rq.ra;
					r.src_b = RSP;
					r.dst_e = RSP;
				end
				IPOPQ: begin
					r.src_a = RSP;
					r.src_b = RSP;
					r.dst_e = RSP;
					r.dst_m = rq.ra;
				end
				default: ;
			endcase
			if (rq.icode == ICALL || rq.icode == IJXX)
				r.val_a = rq.valp;
			else
				r.val_a = operand_of(r.src_a);
			r.val_b = operand_of(r.src_b);
			expected.push_back(r);
		endfunction

		function void compare_field(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %h actual %h", $time, field, want, got);
			end
		endfunction

		function void check_result(operands_t got);
			operands_t want;
			if (expected.size() == 0) begin
				errors++;
				$display("%0t: result item with none expected, icode %h val_a %h val_b %h",
					$time, got.icode, got.val_a, got.val_b);
				return;
			end
			want = expected.pop_front();
			compare_field("e_icode", 64'(want.icode), 64'(got.icode));
			compare_field("e_ifun", 64'(want.ifun), 64'(got.ifun));
			compare_field("dst_e", 64'(want.dst_e), 64'(got.dst_e));
			compare_field("dst_m", 64'(want.dst_m), 64'(got.dst_m));
			compare_field("e_valc", want.valc, got.valc);
			compare_field("val_a", want.val_a, got.val_a);
			compare_field("val_b", want.val_b, got.val_b);
			compare_field("src_a", 64'(want.src_a), 64'(got.src_a));
			compare_field("src_b", 64'(want.src_b), 64'(got.src_b));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] action = '0;
	icode_t     icode = '0;
	logic [3:0] ifun = '0;
	reg_id_t    reg_a = '0;
	reg_id_t    reg_b = '0;
	word_t      const_word = '0;
	word_t      next_pc = '0;
	logic [2:0] slot = '0;
	reg_id_t    dest_reg = '0;
	word_t      write_value = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	icode_t     e_icode;
	logic [3:0] e_ifun;
	reg_id_t    dst_e;
	reg_id_t    dst_m;
	word_t      e_valc;
	word_t      val_a;
	word_t      val_b;
	reg_id_t    src_a;
	reg_id_t    src_b;

	operand_tracker tracker = new();
	bit calm_send = 1'b0;
	bit calm_recv = 1'b0;
	int stall_left = 0;
	int idle_cycles = 0;
	bit moved;

	pipeline_decode_forwarding uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.icode(icode),
		.ifun(ifun),
		.reg_a(reg_a),
		.reg_b(reg_b),
		.const_word(const_word),
		.next_pc(next_pc),
		.slot(slot),
		.dest_reg(dest_reg),
		.write_value(write_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.e_icode(e_icode),
		.e_ifun(e_ifun),
		.dst_e(dst_e),
		.dst_m(dst_m),
		.e_valc(e_valc),
		.val_a(val_a),
		.val_b(val_b),
		.src_a(src_a),
		.src_b(src_b)
	);

	always #10 clk = ~clk;

	function automatic word_t rand_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// bias towards a few registers so bypass hits are common
	function automatic reg_id_t pick_reg();
		if ($urandom_range(0, 1) != 0)
			return reg_id_t'($urandom_range(0, 5));
		return reg_id_t'($urandom_range(0, 15));
	endfunction

	function automatic request_t random_request();
		request_t rq;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			rq.act = ACT_DECODE;
		else if (pick < 75)
			rq.act = ACT_WRITE;
		else if (pick < 97)
			rq.act = ACT_SLOT;
		else
			rq.act = ACT_UNUSED;
		if ($urandom_range(0, 9) != 0)
			rq.icode = icode_t'($urandom_range(IRRMOVQ, IPOPQ));
		else
			rq.icode = icode_t'($urandom_range(0, 15));
		rq.ifun = 4'($urandom_range(0, 15));
		rq.ra = pick_reg();
		rq.rb = pick_reg();
		rq.dest = pick_reg();
		rq.valc = rand_word();
		rq.valp = rand_word();
		rq.wval = rand_word();
		if ($urandom_range(0, 11) != 0)
			rq.slot = 3'($urandom_range(0, SLOT_COUNT - 1));
		else
			rq.slot = 3'($urandom_range(SLOT_COUNT, 7));
		return rq;
	endfunction

	task automatic drive_item(input request_t rq);
		int gap;
		if ($urandom_range(0, 39) == 0)
			calm_send = !calm_send;
		gap = calm_send ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= rq.act;
		icode <= rq.icode;
		ifun <= rq.ifun;
		reg_a <= rq.ra;
		reg_b <= rq.rb;
		const_word <= rq.valc;
		next_pc <= rq.valp;
		slot <= rq.slot;
		dest_reg <= rq.dest;
		write_value <= rq.wval;
		do @(posedge clk); while (in_stall);
	endtask

	// accepted items, result checks, receiver stalls and the watchdog
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			idle_cycles = 0;
		end else begin
			moved = 1'b0;
			if (in_valid && !in_stall) begin
				tracker.note_item({action, icode, ifun, reg_a, reg_b, const_word, next_pc,
					slot, dest_reg, write_value});
				moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				tracker.check_result({e_icode, e_ifun, dst_e, dst_m, e_valc, val_a, val_b,
					src_a, src_b});
				moved = 1'b1;
				if ($urandom_range(0, 39) == 0)
					calm_recv = !calm_recv;
				stall_left = calm_recv ? 0 : $urandom_range(0, 5);
			end else if (stall_left != 0) begin
				stall_left--;
			end
			out_stall <= (stall_left != 0);
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("pipeline_decode_forwarding_test: errors");
				$finish;
			end
		end
	end

	initial begin
		request_t rq;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rq = random_request();
		rq.act = ACT_WRITE;
		rq.dest = 4'd0;
		rq.wval = '1;
		drive_item(rq);
		rq.dest = 4'd14;
		rq.wval = 64'h0123_4567_89ab_cdef;
		drive_item(rq);
		// write to none is dropped
		rq.dest = RNONE;
		rq.wval = 64'hdead_beef_0bad_f00d;
		drive_item(rq);
		rq.act = ACT_SLOT;
		rq.slot = 3'd1;
		rq.dest = 4'd2;
		rq.wval = 64'h8000_0000_0000_0001;
		drive_item(rq);
		rq.slot = 3'd4;
		rq.dest = RSP;
		rq.wval = 64'h7fff_ffff_ffff_fff0;
		drive_item(rq);
		// slot number out of range
		rq.slot = 3'd6;
		rq.dest = 4'd3;
		rq.wval = '1;
		drive_item(rq);
		// slot aimed at none never forwards
		rq.slot = 3'd0;
		rq.dest = RNONE;
		rq.wval = 64'h5555_aaaa_5555_aaaa;
		drive_item(rq);
		rq.act = ACT_UNUSED;
		drive_item(rq);
		for (int i = 0; i < 16; i++) begin
			rq.act = ACT_DECODE;
			rq.icode = icode_t'(i);
			rq.ifun = 4'(15 - i);
			rq.ra = reg_id_t'(i + 9);
			rq.rb = reg_id_t'(i);
			rq.valc = i[0] ? '1 : '0;
			rq.valp = i[0] ? '0 : '1;
			drive_item(rq);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (tracker.expected.size() != 0) @(posedge clk);
			end
			drive_item(random_request());
		end
		in_valid <= 1'b0;

		while (tracker.expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("pipeline_decode_forwarding_test: clean");
		else
			$display("pipeline_decode_forwarding_test: errors");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/pdf_pkg.sv
rtl/pdf_ram.sv
rtl/pdf_decode.sv
rtl/pdf_bypass.sv
rtl/pipeline_decode_forwarding.sv
tb/pipeline_decode_forwarding_test.sv
